@@ rtl/emfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Energy meter frame decoder package
// Shared types and constants for the metering chip frame decoder.
// ----------------------------------------------------------------------------
package emfd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [4:0] count_t;

  localparam int unsigned FrameLen = 24;

  localparam count_t CNT_FRAME = 5'd24;
  localparam count_t CNT_MAX   = 5'd25;
  localparam count_t SUM_FIRST = 5'd2;
  localparam count_t SUM_LAST  = 5'd22;

  localparam int unsigned HdrIdx = 1;
  localparam int unsigned SumIdx = 23;
  localparam int unsigned UpdIdx = 20;
  localparam int unsigned UpdOvfBit = 7;

  localparam byte_t HEADER_VALUE = 8'h5A;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_GAP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LENGTH   = 2'd1,
    ST_HEADER   = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_e;

endpackage
`default_nettype wire

@@ rtl/energy_meter_frame_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Energy meter frame decoder
// Collects metering chip UART words into a 24-byte frame, checks and unpacks it.
// ----------------------------------------------------------------------------
// A result is registered and appears in the cycle after the gap word that ends its burst.
// Throughput: one input word per cycle; byte words shift the cell chain and a
// running sum, so no work remains at the gap beyond one compare stage.
// Any input word waits only while an earlier result sits untaken in the output
// register. Reset clears the byte count, sum, overflow counter and output
// valid; the frame cells hold no reset value and are rewritten each burst.
// ----------------------------------------------------------------------------
module energy_meter_frame_decoder (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  wire          s_axis_tuser_i,   // [0] mode
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  output logic [207:0] m_axis_tdata_o,   // [7:0] state_byte, [31:8] voltage_param,
                                         // [55:32] voltage_period, [79:56] current_param,
                                         // [103:80] current_period, [127:104] power_param,
                                         // [151:128] power_period, [159:152] update_byte,
                                         // [175:160] pulse_count, [207:176] pulse_overflows
  output logic [1:0]   m_axis_tuser_o    // [1:0] status
);
  import emfd_pkg::*;

  logic          s_fire;
  logic          is_gap;
  logic          shift;
  byte_t         cell_q [FrameLen];
  byte_t         fb     [FrameLen];

  count_t        cnt_q, cnt_d;
  byte_t         sum_q, sum_d;
  logic [31:0]   ovf_q, ovf_d;
  logic [31:0]   ovf_inc;
  logic          m_valid_q, m_valid_d;
  logic [207:0]  m_data_q, m_data_d;
  status_e       m_status_q, m_status_d;

  status_e       status;
  logic          emit;
  logic          frame_ok;
  logic          bump;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign is_gap = (s_axis_tuser_i == MODE_GAP);
  assign shift  = s_fire && !is_gap && (cnt_q < CNT_FRAME);

  for (genvar k = 0; k < FrameLen; k++) begin : g_cell
    if (k == 0) begin : g_head
      emfd_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .byte_i  (s_axis_tdata_i),
        .byte_o  (cell_q[k])
      );
    end else begin : g_body
      emfd_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .byte_i  (cell_q[k-1]),
        .byte_o  (cell_q[k])
      );
    end
    assign fb[FrameLen-1-k] = cell_q[k];
  end

  always_comb begin
    priority if (cnt_q != CNT_FRAME) begin
      status = ST_LENGTH;
    end else if (fb[HdrIdx] != HEADER_VALUE) begin
      status = ST_HEADER;
    end else if (sum_q != fb[SumIdx]) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_OK;
    end
  end

  assign emit     = s_fire && is_gap && (cnt_q != '0);
  assign frame_ok = (status == ST_OK);
  assign bump     = frame_ok && fb[UpdIdx][UpdOvfBit];
  assign ovf_inc  = ovf_q + 32'd1;

  always_comb begin
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    ovf_d      = ovf_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_status_d = m_status_q;
    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if (s_fire) begin
      if (is_gap) begin
        cnt_d = '0;
        sum_d = '0;
        if (emit) begin
          m_valid_d  = 1'b1;
          m_status_d = status;
          m_data_d   = '0;
          if (frame_ok) begin
            if (bump) begin
              ovf_d = ovf_inc;
            end
            m_data_d = {bump ? ovf_inc : ovf_q,
                        fb[21], fb[22],
                        fb[20],
                        fb[17], fb[18], fb[19],
                        fb[14], fb[15], fb[16],
                        fb[11], fb[12], fb[13],
                        fb[8],  fb[9],  fb[10],
                        fb[5],  fb[6],  fb[7],
                        fb[2],  fb[3],  fb[4],
                        fb[0]};
          end
        end
      end else begin
        if (cnt_q < CNT_MAX) begin
          cnt_d = cnt_q + 5'd1;
        end
        if ((cnt_q >= SUM_FIRST) && (cnt_q <= SUM_LAST)) begin
          sum_d = sum_q + s_axis_tdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      sum_q     <= '0;
      ovf_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      ovf_q     <= ovf_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q   <= m_data_d;
    m_status_q <= m_status_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_status_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("byte count beyond saturation");

  a_gap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && is_gap) |=> (cnt_q == '0) && (sum_q == '0))
    else $error("gap did not clear burst state");

  a_gap_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_valid_q)
    else $error("non-empty burst gave no result");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_status_q != ST_OK)) |-> (m_data_q == '0))
    else $error("failed frame carries data");

  a_ovf_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !emit |=> $stable(ovf_q))
    else $error("overflow counter moved without a frame");

endmodule
`default_nettype wire

@@ rtl/emfd_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame byte cell
// One byte stage of the frame shift chain; takes its neighbor's byte on shift.
// ----------------------------------------------------------------------------
module emfd_cell (
  input  wire                   clk_i,
  input  wire                   shift_i,
  input  wire emfd_pkg::byte_t  byte_i,
  output emfd_pkg::byte_t       byte_o
);
  import emfd_pkg::*;

  byte_t byte_q;
  byte_t byte_d;

  always_comb begin
    byte_d = shift_i ? byte_i : byte_q;
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule
`default_nettype wire
